>>> sv/idle_timeout_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// idle timeout frame receiver assertion macros
// clocked property wrappers used by the receiver design file
// ----------------------------------------------------------------------------
`ifndef IDLE_TIMEOUT_FRAME_RECEIVER_ASSERT_SVH
`define IDLE_TIMEOUT_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ITFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ITFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/itfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfr_pkg
// shared types and constants of the idle timeout frame receiver
// ----------------------------------------------------------------------------
package itfr_pkg;

   localparam int unsigned BUF_DEPTH_DEFAULT = 64;
   localparam int unsigned KIND_W            = 2;
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned LENGTH_W          = 7;
   localparam int unsigned TICKS_W           = 16;

   localparam logic [TICKS_W-1:0] QUIET_TICKS_RESET = 16'd10;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_FETCH = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

endpackage

>>> sv/itfr_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfr_frame_mem
// frame byte store, one write and one registered read port
// ----------------------------------------------------------------------------
module itfr_frame_mem #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [itfr_pkg::BYTE_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [itfr_pkg::BYTE_W-1:0]   rd_data
);
   import itfr_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/idle_timeout_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_timeout_frame_receiver
// collects bytes into a frame store and closes the frame after a quiet gap
// ----------------------------------------------------------------------------
// byte and tick transfers: no result, a new one every cycle while idle and the output is free
// not-ready fetch: result registered in the cycle after the transfer
// ready fetch of n bytes: one store read plus one output load each byte, the load
//   waiting while the output is held, paced by the single read port of the frame store
// reset (synchronous): count, countdown and ready cleared, quiet_ticks to 10;
//   the frame store is not cleared, only written entries are ever read
`include "idle_timeout_frame_receiver_assert.svh"

module idle_timeout_frame_receiver #(
   parameter int unsigned BUF_DEPTH = itfr_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [itfr_pkg::KIND_W-1:0]     req_kind,
   input  logic [itfr_pkg::BYTE_W-1:0]     req_rx_byte,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_frame_ok,
   output logic [itfr_pkg::BYTE_W-1:0]     rsp_frame_byte,
   output logic [itfr_pkg::LENGTH_W-1:0]   rsp_frame_length,
   output logic                            rsp_last,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [itfr_pkg::TICKS_W-1:0]    csr_quiet_ticks
);
   import itfr_pkg::*;

   // store address and byte count widths follow the depth
   localparam int unsigned ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(BUF_DEPTH + 1);

   // idle: takes transfers; read: issue store read; load: move byte to output
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type              state_ff,       state_in;
   logic [CNT_W-1:0]       count_ff,       count_in;
   logic [TICKS_W-1:0]     countdown_ff,   countdown_in;
   logic                   frame_ready_ff, frame_ready_in;
   logic [TICKS_W-1:0]     quiet_ticks_ff, quiet_ticks_in;
   logic [ADDR_W-1:0]      rd_idx_ff,      rd_idx_in;
   logic                   rsp_valid_ff,   rsp_valid_in;
   logic                   rsp_ok_ff,      rsp_ok_in;
   logic [BYTE_W-1:0]      rsp_byte_ff,    rsp_byte_in;
   logic [LENGTH_W-1:0]    rsp_length_ff,  rsp_length_in;
   logic                   rsp_last_ff,    rsp_last_in;

   logic                   out_free;
   logic                   req_xfer;
   logic                   load_xfer;
   logic                   rd_is_last;
   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [BYTE_W-1:0]      mem_rd_data;
   kind_type               kind;

   assign kind       = kind_type'(req_kind);
   // output register can take a new result this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_xfer   = req_valid && req_ready;
   assign load_xfer  = (state_ff == ST_LOAD) && out_free;
   assign rd_is_last = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   // append only while the store has room
   assign mem_wr_en  = req_xfer && (kind == KIND_BYTE) && (count_ff < CNT_W'(BUF_DEPTH));
   assign mem_rd_en  = (state_ff == ST_READ);

   itfr_frame_mem #(
      .DEPTH  (BUF_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      countdown_in   = countdown_ff;
      frame_ready_in = frame_ready_ff;
      quiet_ticks_in = quiet_ticks_ff;
      rd_idx_in      = rd_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_valid) begin
         quiet_ticks_in = csr_quiet_ticks;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (kind)
                  KIND_BYTE: begin
                     if (mem_wr_en) begin
                        count_in     = count_ff + CNT_W'(1);
                        countdown_in = quiet_ticks_ff;
                     end
                  end
                  KIND_TICK: begin
                     if (countdown_ff != '0) begin
                        countdown_in = countdown_ff - TICKS_W'(1);
                        // countdown hits zero with bytes held: frame closes
                        if ((countdown_ff == TICKS_W'(1)) && (count_ff != '0)) begin
                           frame_ready_in = 1'b1;
                        end
                     end
                  end
                  KIND_FETCH: begin
                     if (frame_ready_ff && (count_ff != '0)) begin
                        rd_idx_in = '0;
                        state_in  = ST_READ;
                     end else begin
                        // not-ready answer, also clears a stale ready flag
                        frame_ready_in = 1'b0;
                        rsp_valid_in   = 1'b1;
                        rsp_ok_in      = 1'b0;
                        rsp_byte_in    = '0;
                        rsp_length_in  = '0;
                        rsp_last_in    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load_xfer) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = 1'b1;
               rsp_byte_in   = mem_rd_data;
               rsp_length_in = LENGTH_W'(count_ff);
               rsp_last_in   = rd_is_last;
               if (rd_is_last) begin
                  // frame delivered: empty the store
                  count_in       = '0;
                  frame_ready_in = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + ADDR_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         countdown_ff   <= '0;
         frame_ready_ff <= 1'b0;
         quiet_ticks_ff <= QUIET_TICKS_RESET;
         rd_idx_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         countdown_ff   <= countdown_in;
         frame_ready_ff <= frame_ready_in;
         quiet_ticks_ff <= quiet_ticks_in;
         rd_idx_ff      <= rd_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      // result payload, no reset needed
      rsp_ok_ff     <= rsp_ok_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_length_ff <= rsp_length_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_ok     = rsp_ok_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_frame_length = rsp_length_ff;
   assign rsp_last         = rsp_last_ff;

   // byte count stays within the store
   `ITFR_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(BUF_DEPTH),
      "byte count beyond store depth")

   // a ready frame always holds bytes
   `ITFR_ASSERT_NOW(a_ready_nonempty, frame_ready_ff, count_ff != '0,
      "frame ready with empty store")

   // the read index never passes the held bytes
   `ITFR_ASSERT_NOW(a_rd_idx_bound, state_ff != ST_IDLE,
      CNT_W'(rd_idx_ff) < count_ff, "read index beyond byte count")

   // the last byte load empties the store and returns to idle
   `ITFR_ASSERT_NEXT(a_last_clears, load_xfer && rd_is_last,
      (count_ff == '0) && !frame_ready_ff && (state_ff == ST_IDLE),
      "frame not cleared after last byte")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle timeout frame receiver testbench
// drives byte, tick and fetch transfers with random idling on both channels,
// predicts every result from a local copy of the receiver state and checks
// them in order; quiet_ticks is swept through several settings between phases
// ----------------------------------------------------------------------------
module testbench;
   import itfr_pkg::*;

   localparam int unsigned BUF_DEPTH    = BUF_DEPTH_DEFAULT;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          MAX_REPORTS  = 10;

   // one result transfer
   typedef struct packed {
      logic                ok;
      logic [BYTE_W-1:0]   data;
      logic [LENGTH_W-1:0] len;
      logic                is_last;
   } frame_result_type;

   // one row of the directed table; want only counts when typed is set
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] rx;
      bit                typed;
      frame_result_type  want;
   } stim_row_type;

   localparam frame_result_type NOT_READY = '{ok: 1'b0, data: '0, len: '0, is_last: 1'b1};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_frame_ok;
   logic [BYTE_W-1:0]   rsp_frame_byte;
   logic [LENGTH_W-1:0] rsp_frame_length;
   logic                rsp_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [TICKS_W-1:0]  csr_quiet_ticks;

   // predicted receiver state
   logic [BYTE_W-1:0]  held_bytes [BUF_DEPTH];
   int                 held_count;
   logic [TICKS_W-1:0] countdown;
   bit                 frame_closed;
   logic [TICKS_W-1:0] quiet_reload;

   frame_result_type expected_results [$];
   stim_row_type     directed_rows [$];

   // run bookkeeping
   int mismatches;
   int items_sent;
   int results_checked;
   int frames_seen;
   int not_ready_seen;
   int bytes_dropped;
   int settings_used;
   bit no_idle;

   idle_timeout_frame_receiver #(
      .BUF_DEPTH(BUF_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_quiet_ticks  (csr_quiet_ticks)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // advance the receiver state by one accepted transfer and queue its results
   function automatic void predict_receiver(kind_type kind, logic [BYTE_W-1:0] rx);
      frame_result_type r;
      int               i;
      case (kind)
         KIND_BYTE: begin
            if (held_count < BUF_DEPTH) begin
               held_bytes[held_count] = rx;
               held_count++;
               countdown = quiet_reload;
            end else begin
               // full store: byte lost, countdown keeps running
               bytes_dropped++;
            end
         end
         KIND_TICK: begin
            if (countdown != 0) begin
               countdown--;
               if (countdown == 0 && held_count != 0) frame_closed = 1'b1;
            end
         end
         KIND_FETCH: begin
            if (frame_closed && held_count != 0) begin
               for (i = 0; i < held_count; i++) begin
                  r.ok      = 1'b1;
                  r.data    = held_bytes[i];
                  r.len     = LENGTH_W'(held_count);
                  r.is_last = (i == held_count - 1);
                  expected_results.push_back(r);
               end
               held_count = 0;
            end else begin
               expected_results.push_back(NOT_READY);
            end
            // countdown is left alone on purpose
            frame_closed = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(kind_type kind, logic [BYTE_W-1:0] rx, bit typed,
                                   frame_result_type want);
      stim_row_type row;
      row.kind  = kind;
      row.rx    = rx;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // one request transfer; a typed row replaces the predicted single result
   task automatic send_item(kind_type kind, logic [BYTE_W-1:0] rx, bit typed,
                            frame_result_type want);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      predict_receiver(kind, rx);
      if (typed) begin
         void'(expected_results.pop_back());
         expected_results.push_back(want);
      end
      if (kind != KIND_NONE) items_sent++;
   endtask

   task automatic send_plain(kind_type kind, logic [BYTE_W-1:0] rx);
      send_item(kind, rx, 1'b0, NOT_READY);
   endtask

   // stop requests and let every pending result drain out
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_quiet_ticks(logic [TICKS_W-1:0] value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_quiet_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      quiet_reload = value;
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // bytes with stray ticks, a quiet gap near a small reload, one or two fetches
   task automatic send_frame(bit force_full);
      int  nb;
      int  nt;
      int  i;
      bit  long_frame;
      long_frame = force_full ||
                   (quiet_reload != 0 && quiet_reload <= 8 && $urandom_range(0, 19) == 0);
      nb = long_frame ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (i = 0; i < nb; i++) begin
         send_plain(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) == 0) send_plain(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
      end
      if (quiet_reload == 0 || quiet_reload > 8) begin
         nt = $urandom_range(1, 4);
      end else begin
         nt = int'(quiet_reload) + $urandom_range(0, 1);
         if ($urandom_range(0, 5) == 0) nt--;
      end
      repeat (nt) send_plain(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
      send_plain(KIND_FETCH, BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) send_plain(KIND_FETCH, BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic run_phase(logic [TICKS_W-1:0] quiet, int budget, bit force_full);
      int target;
      int n;
      bit first;
      quiesce();
      write_quiet_ticks(quiet);
      target = items_sent + budget;
      first  = force_full;
      while (items_sent < target) begin
         no_idle = ($urandom_range(0, 5) == 0);
         if (first || $urandom_range(0, 9) < 7) begin
            send_frame(first);
            first = 1'b0;
         end else begin
            // noise: any kind, including the unused one
            send_plain(kind_type'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
         end
      end
      // held bytes, countdown <= 16: tick it out and fetch before the next setting
      n = int'(countdown);
      if (held_count != 0 && n <= 16) begin
         repeat (n) send_plain(KIND_TICK, 8'h00);
         send_plain(KIND_FETCH, 8'h00);
      end
   endtask

   // result side: random stall before each transfer
   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // in-order check of every result transfer
   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.ok      = rsp_frame_ok;
         got.data    = rsp_frame_byte;
         got.len     = rsp_frame_length;
         got.is_last = rsp_last;
         results_checked++;
         if (got.ok && got.is_last) frames_seen++;
         if (!got.ok) not_ready_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing expected: ok %0d byte %02h len %0d last %0d",
                        $realtime, got.ok, got.data, got.len, got.is_last);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result mismatch: expected ok %0d byte %02h len %0d last %0d,",
                           $realtime, want.ok, want.data, want.len, want.is_last,
                           " got ok %0d byte %02h len %0d last %0d",
                           got.ok, got.data, got.len, got.is_last);
            end
         end
      end
   end

   // hard stop if the handshakes hang
   initial begin : watchdog
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int i;
      mismatches      = 0;
      items_sent      = 0;
      results_checked = 0;
      frames_seen     = 0;
      not_ready_seen  = 0;
      bytes_dropped   = 0;
      settings_used   = 0;
      no_idle         = 1'b0;
      held_count      = 0;
      countdown       = '0;
      frame_closed    = 1'b0;
      quiet_reload    = QUIET_TICKS_RESET;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_NONE;
      req_rx_byte     = '0;
      csr_valid       = 1'b0;
      csr_quiet_ticks = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, runs on the reset value of quiet_ticks (10)
      add_row(KIND_FETCH, 8'h00, 1'b1, NOT_READY);   // nothing received yet
      add_row(KIND_NONE,  8'hFF, 1'b0, NOT_READY);   // unused kind, ignored
      add_row(KIND_BYTE,  8'h00, 1'b0, NOT_READY);
      add_row(KIND_BYTE,  8'hFF, 1'b0, NOT_READY);
      for (i = 0; i < 9; i++) add_row(KIND_TICK, 8'h00, 1'b0, NOT_READY);
      add_row(KIND_FETCH, 8'h00, 1'b1, NOT_READY);   // one tick short of quiet
      add_row(KIND_TICK,  8'h00, 1'b0, NOT_READY);   // frame closes here
      add_row(KIND_BYTE,  8'hA5, 1'b0, NOT_READY);   // append while ready
      add_row(KIND_FETCH, 8'h00, 1'b0, NOT_READY);   // three bytes out
      add_row(KIND_FETCH, 8'h00, 1'b1, NOT_READY);   // store just emptied
      add_row(KIND_TICK,  8'h00, 1'b0, NOT_READY);   // countdown runs, nothing held
      add_row(KIND_FETCH, 8'h00, 1'b1, NOT_READY);
      foreach (directed_rows[k])
         send_item(directed_rows[k].kind, directed_rows[k].rx,
                   directed_rows[k].typed, directed_rows[k].want);

      // random part over several quiet_ticks settings, extremes included
      run_phase(16'd1,     75,  1'b0);
      run_phase(16'd0,     25,  1'b0);   // countdown reloads to zero
      run_phase(16'd3,     95,  1'b1);   // opens with a long frame, 60-70 bytes
      run_phase(16'd2,     85,  1'b1);
      run_phase(TICKS_W'($urandom_range(1, 6)), 65, 1'b0);
      run_phase(16'hFFFF,  25,  1'b0);   // frames cannot close in this phase
      quiesce();

      $display("covered %0d request transfers under %0d quiet_ticks settings, %0d bytes dropped",
               items_sent, settings_used + 1, bytes_dropped);
      $display("checked %0d results: %0d frames delivered, %0d not-ready answers",
               results_checked, frames_seen, not_ready_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/itfr_pkg.sv
sv/itfr_frame_mem.sv
sv/idle_timeout_frame_receiver.sv
test/testbench.sv
